// ----- hdl/crc32_message_check_macros.svh -----
// ----------------------------------------------------------------------------
// crc32_message_check assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC32_MESSAGE_CHECK_MACROS_SVH
`define CRC32_MESSAGE_CHECK_MACROS_SVH

// same-cycle implication
`define CRCMC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc32_message_check: assertion failed");

// next-cycle implication
`define CRCMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc32_message_check: assertion failed");

`endif

// ----- hdl/crcmc_pkg.sv -----
// ----------------------------------------------------------------------------
// crcmc_pkg
// Types, constants and the byte-wide CRC-32 update for the message checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crcmc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [7:0]  HEADER_BYTES_RST = 8'd32;
  localparam logic [15:0] MAX_LENGTH_RST   = 16'd8192;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned OUT_DATA_W = 40;

  // register index, taken from paddr[2]
  localparam logic REG_HEADER_BYTES = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } crcmc_op_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_INVALID  = 2'd2
  } crcmc_status_e;

  typedef struct packed {
    crcmc_op_e   opcode;
    logic [15:0] message_length;
    logic [31:0] expected_checksum;
    logic [7:0]  data_byte;
  } crcmc_item_t;

  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [15:0] max_length;
  } crcmc_cfg_t;

  // one byte through the reflected CRC, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/crcmc_cfg.sv -----
// ----------------------------------------------------------------------------
// crcmc_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcmc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [crcmc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output crcmc_pkg::crcmc_cfg_t            cfg_o
);
  import crcmc_pkg::*;

  logic [7:0]  header_bytes_q;
  logic [15:0] max_length_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_bytes_q <= HEADER_BYTES_RST;
      max_length_q   <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_HEADER_BYTES) begin
        header_bytes_q <= pwdata[7:0];
      end else begin
        max_length_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_LENGTH) begin
      prdata = {16'd0, max_length_q};
    end else begin
      prdata = {24'd0, header_bytes_q};
    end
  end

  assign cfg_o.header_bytes = header_bytes_q;
  assign cfg_o.max_length   = max_length_q;

endmodule

`default_nettype wire

// ----- hdl/crcmc_in_stage.sv -----
// ----------------------------------------------------------------------------
// crcmc_in_stage
// Input register: captures one item and holds it until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crcmc_in_stage (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire crcmc_pkg::crcmc_item_t in_item_i,
  output logic                        item_valid_o,
  output crcmc_pkg::crcmc_item_t      item_o,
  input  wire logic                   item_take_i
);
  import crcmc_pkg::*;

  logic        valid_q, valid_d;
  crcmc_item_t item_q;
  logic        load;

  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !item_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ----- hdl/crcmc_engine.sv -----
// ----------------------------------------------------------------------------
// crcmc_engine
// Message state, byte-wide CRC update, length check and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_message_check_macros.svh"

module crcmc_engine (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire crcmc_pkg::crcmc_cfg_t  cfg_i,
  input  wire logic                   item_valid_i,
  input  wire crcmc_pkg::crcmc_item_t item_i,
  output logic                        item_take_o,
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output crcmc_pkg::crcmc_status_e    res_status_o,
  output logic [31:0]                 res_crc_o
);
  import crcmc_pkg::*;

  logic [31:0]   crc_q, crc_d;
  logic [15:0]   left_q, left_d;
  logic [31:0]   expected_q, expected_d;
  logic          in_msg_q, in_msg_d;
  logic          out_valid_q, out_valid_d;
  crcmc_status_e status_q, status_d;
  logic [31:0]   out_crc_q, out_crc_d;

  logic          emit;
  logic [31:0]   crc_next;
  logic [31:0]   final_crc;
  logic          len_bad;
  logic [15:0]   payload_len;

  assign item_take_o = item_valid_i && (!out_valid_q || res_ready_i);

  assign crc_next    = crc_byte(crc_q, item_i.data_byte);
  assign final_crc   = ~crc_next;
  assign len_bad     = (item_i.message_length < {8'd0, cfg_i.header_bytes}) ||
                       (item_i.message_length > cfg_i.max_length);
  assign payload_len = item_i.message_length - {8'd0, cfg_i.header_bytes};

  always_comb begin
    crc_d      = crc_q;
    left_d     = left_q;
    expected_d = expected_q;
    in_msg_d   = in_msg_q;
    emit       = 1'b0;
    status_d   = status_q;
    out_crc_d  = out_crc_q;
    if (item_take_o) begin
      case (item_i.opcode)
        OP_START: begin
          crc_d    = CRC_INIT;
          in_msg_d = 1'b0;
          if (len_bad) begin
            emit      = 1'b1;
            status_d  = ST_INVALID;
            out_crc_d = '0;
          end else begin
            left_d     = payload_len;
            expected_d = item_i.expected_checksum;
            if (payload_len == '0) begin
              // empty payload: CRC of no bytes is zero
              emit      = 1'b1;
              status_d  = (item_i.expected_checksum == '0) ? ST_MATCH : ST_MISMATCH;
              out_crc_d = '0;
            end else begin
              in_msg_d = 1'b1;
            end
          end
        end
        OP_BYTE: begin
          // drop stray bytes outside a message
          if (in_msg_q) begin
            crc_d  = crc_next;
            left_d = left_q - 16'd1;
            if (left_q == 16'd1) begin
              in_msg_d  = 1'b0;
              emit      = 1'b1;
              status_d  = (final_crc == expected_q) ? ST_MATCH : ST_MISMATCH;
              out_crc_d = final_crc;
            end
          end
        end
        default: begin
          in_msg_d = in_msg_q;
        end
      endcase
    end
  end

  assign out_valid_d = emit || (out_valid_q && !res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      left_q      <= '0;
      expected_q  <= '0;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      left_q      <= left_d;
      expected_q  <= expected_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q  <= status_d;
      out_crc_q <= out_crc_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = status_q;
  assign res_crc_o    = out_crc_q;

  `CRCMC_ASSERT_IMPL(a_invalid_zero_crc, out_valid_q && (status_q == ST_INVALID), out_crc_q == '0)
  `CRCMC_ASSERT_IMPL(a_match_consistent,
    out_valid_q && (status_q != ST_INVALID),
    (status_q == ST_MATCH) == (out_crc_q == expected_q))
  `CRCMC_ASSERT_IMPL(a_open_has_bytes, in_msg_q, left_q != '0)
  `CRCMC_ASSERT_NEXT(a_no_take_when_stalled, out_valid_q && !res_ready_i && !item_valid_i,
    out_valid_q)

endmodule

`default_nettype wire

// ----- hdl/crc32_message_check.sv -----
// ----------------------------------------------------------------------------
// crc32_message_check
// Message integrity checker using reflected CRC-32 over the payload bytes.
// ----------------------------------------------------------------------------
// A start item (tuser = 0) carries the total message length and the expected
// checksum; a length below header_bytes or above max_length returns status 2
// with CRC 0 at once, and a length equal to header_bytes returns CRC 0 at
// once. Otherwise the next (length - header_bytes) payload items (tuser = 1)
// feed the CRC, and the last one returns the inverted CRC with status 0 on a
// match and 1 on a mismatch. Payload items with no open message are dropped,
// and a new start abandons an open message silently. The block takes one
// item every cycle unless the result side stalls it; an accepted item goes
// from the input register through the 8-bit unrolled CRC update into the
// result register. Backpressure on the result side stalls input only while
// the result register is full and not being taken.
`default_nettype none

module crc32_message_check (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] message_length, [47:16] expected_checksum, [55:48] data_byte
  input  wire logic [crcmc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  wire logic                           s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] status, [33:2] computed_crc, [39:34] zero
  output logic [crcmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [crcmc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import crcmc_pkg::*;

  crcmc_cfg_t    cfg;
  crcmc_item_t   in_item;
  crcmc_item_t   item;
  logic          item_valid;
  logic          item_take;
  crcmc_status_e res_status;
  logic [31:0]   res_crc;

  assign in_item.opcode            = crcmc_op_e'(s_axis_tuser);
  assign in_item.message_length    = s_axis_tdata[15:0];
  assign in_item.expected_checksum = s_axis_tdata[47:16];
  assign in_item.data_byte         = s_axis_tdata[55:48];

  crcmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crcmc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  crcmc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_crc_o    (res_crc)
  );

  assign m_axis_tdata = {6'd0, res_crc, res_status};

endmodule

`default_nettype wire
